### sv/tidu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tidu_pkg: shared types and constants of the trigger ID unwrap ring buffer
// Action and status codes, field widths, reset values and the result of the
// trigger counter widening logic.
// ---------------------------------------------------------------------------
package tidu_pkg;

    // field widths
    localparam int ActionW   = 2;
    localparam int LowW      = 16;
    localparam int ExtW      = 8;
    localparam int WordW     = 32;
    localparam int StatusW   = 3;
    localparam int OccW      = 11;
    localparam int GapW      = 16;

    // ring depth default
    localparam int TIDU_DEPTH = 1024;

    // reset value of the gap window register
    localparam logic [GapW-1:0] GAP_RESET = 16'd200;

    // action codes
    localparam logic [ActionW-1:0] ACT_FRAME = 2'd0;
    localparam logic [ActionW-1:0] ACT_PEEK  = 2'd1;
    localparam logic [ActionW-1:0] ACT_POP   = 2'd2;
    localparam logic [ActionW-1:0] ACT_CLEAR = 2'd3;

    // status codes
    localparam logic [StatusW-1:0] ST_STORED   = 3'd0;
    localparam logic [StatusW-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [StatusW-1:0] ST_BAD      = 3'd2;
    localparam logic [StatusW-1:0] ST_EMPTY    = 3'd3;
    localparam logic [StatusW-1:0] ST_READ     = 3'd4;

    // widening result for one frame
    typedef struct packed {
        logic             bad;       // no candidate inside the window
        logic [WordW-1:0] id;        // assigned trigger ID when not bad
        logic [WordW-1:0] exp_next;  // expected ID after this frame
    } t_unwrap;

endpackage

### sv/tidu_unwrap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tidu_unwrap: 16-bit to 32-bit trigger counter widening
// Takes the expected ID on a low-bit match, else the same-page, then the
// next-page candidate ahead by less than the gap window; else flags bad.
// ---------------------------------------------------------------------------
module tidu_unwrap
    import tidu_pkg::*;
(
    input  logic [WordW-1:0] i_expected,
    input  logic             i_first,
    input  logic [LowW-1:0]  i_counter_low,
    input  logic [GapW-1:0]  i_gap,
    output t_unwrap          o_res
);

    logic [WordW-1:0] exp_eff;
    logic [WordW-1:0] g0;
    logic [WordW-1:0] g1;
    logic [WordW-1:0] d0;
    logic [WordW-1:0] d1;
    logic [WordW-1:0] gap_ext;
    logic             hit0;
    logic             hit1;
    logic             match;
    logic [WordW-1:0] base;

    // first frame seeds the expected ID with its own counter
    assign exp_eff = i_first ? {{(WordW-LowW){1'b0}}, i_counter_low} : i_expected;
    assign match   = (i_counter_low == exp_eff[LowW-1:0]);

    // candidates in the current and the next 64K page
    assign g0      = {exp_eff[WordW-1:LowW], i_counter_low};
    assign g1      = {exp_eff[WordW-1:LowW] + 16'd1, i_counter_low};
    assign d0      = g0 - exp_eff;
    assign d1      = g1 - exp_eff;
    assign gap_ext = {{(WordW-GapW){1'b0}}, i_gap};
    assign hit0    = (g0 > exp_eff) && (d0 < gap_ext);
    assign hit1    = (g1 > exp_eff) && (d1 < gap_ext);

    always_comb begin
        o_res.bad = 1'b0;
        base      = exp_eff;
        priority if (match) begin
            base = exp_eff;
        end else if (hit0) begin
            base = g0;
        end else if (hit1) begin
            base = g1;
        end else begin
            o_res.bad = 1'b1;
        end
        o_res.id       = base;
        // expected always steps one past the ID used, bad frames included
        o_res.exp_next = base + 32'd1;
    end

endmodule

### sv/tidu_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tidu_ring: event ring storage
// One-write one-read memory of trigger ID and payload pairs with a registered
// read and a bypass for a write to the address read in the same cycle.
// ---------------------------------------------------------------------------
module tidu_ring
    import tidu_pkg::*;
#(
    parameter int DEPTH = TIDU_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int W     = 2 * WordW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rd;
    logic [W-1:0] r_byp_data;
    logic         r_byp;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd <= mem[i_raddr];
    end

    // same-cycle write to the read address: read returns old data, keep new
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_rd;

endmodule

### sv/trigger_id_unwrap_ring_buffer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trigger_id_unwrap_ring_buffer: trigger ID widening event buffer
// Widens 16-bit frame trigger counters to 32-bit IDs, stores ID and payload
// in a ring, and serves peek, pop and clear requests with running totals.
// ---------------------------------------------------------------------------
// The block takes one beat per clock while the output is not stalled and
// returns exactly one result beat for each: the beat lands in an input
// register, is resolved by the widening logic and the ring bookkeeping, and
// leaves from a result register. The ring read is issued ahead, at the read
// slot left by the previous beat, so back-to-back pops and reads right after
// a write run at full rate. The statistics outputs show the state after the
// beat on the output port. The gap window register is written through
// i_cfg_we/i_cfg_data, by the user only while idle; the block does not check.
module trigger_id_unwrap_ring_buffer
    import tidu_pkg::*;
#(
    parameter int DEPTH = TIDU_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [GapW-1:0]    i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ActionW-1:0] i_action,
    input  logic [LowW-1:0]    i_counter_low,
    input  logic [ExtW-1:0]    i_frame_extension,
    input  logic [WordW-1:0]   i_payload,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [StatusW-1:0] o_status,
    output logic [WordW-1:0]   o_trigger_id,
    output logic [WordW-1:0]   o_entry_payload,
    output logic [OccW-1:0]    o_occupancy,
    output logic [WordW-1:0]   o_start_trigger,
    output logic [WordW-1:0]   o_latest_trigger,
    output logic [WordW-1:0]   o_input_total,
    output logic [WordW-1:0]   o_bad_total,
    output logic [WordW-1:0]   o_overflow_total,
    output logic [ExtW-1:0]    o_extension
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // input register
    logic               r_in_valid;
    logic [ActionW-1:0] r_in_action;
    logic [LowW-1:0]    r_in_low;
    logic [ExtW-1:0]    r_in_ext;
    logic [WordW-1:0]   r_in_payload;

    // result register
    logic               r_out_valid;
    logic [StatusW-1:0] r_out_status;
    logic [WordW-1:0]   r_out_id;
    logic [WordW-1:0]   r_out_payload;

    // block state
    logic [GapW-1:0]  r_gap;
    logic [WordW-1:0] r_write_total, n_write_total;
    logic [WordW-1:0] r_read_total,  n_read_total;
    logic [AW-1:0]    r_wr_slot,     n_wr_slot;
    logic [AW-1:0]    r_rd_slot,     n_rd_slot;
    logic [AW-1:0]    r_held_slot,   n_held_slot;
    logic [WordW-1:0] r_expected,    n_expected;
    logic             r_first,       n_first;
    logic [WordW-1:0] r_first_trig,  n_first_trig;
    logic [WordW-1:0] r_last_trig,   n_last_trig;
    logic [ExtW-1:0]  r_ext,         n_ext;
    logic [WordW-1:0] r_frames_in,   n_frames_in;
    logic [WordW-1:0] r_frames_bad,  n_frames_bad;
    logic [WordW-1:0] r_frames_ovf,  n_frames_ovf;

    logic [StatusW-1:0]   n_status;
    logic [WordW-1:0]     n_id;
    logic [WordW-1:0]     n_payload;
    logic                 fire;
    logic                 empty;
    logic                 ring_we;
    logic [2*WordW-1:0]   ring_rdata;
    logic [WordW-1:0]     occ_full;
    t_unwrap              unw;

    // handshakes
    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_action  <= i_action;
            r_in_low     <= i_counter_low;
            r_in_ext     <= i_frame_extension;
            r_in_payload <= i_payload;
        end
    end

    // trigger counter widening
    tidu_unwrap u_unwrap (
        .i_expected    (r_expected),
        .i_first       (r_first),
        .i_counter_low (r_in_low),
        .i_gap         (r_gap),
        .o_res         (unw)
    );

    assign occ_full = r_write_total - r_read_total;
    assign empty    = (occ_full == '0);

    // per-beat bookkeeping
    always_comb begin
        n_write_total = r_write_total;
        n_read_total  = r_read_total;
        n_wr_slot     = r_wr_slot;
        n_rd_slot     = r_rd_slot;
        n_held_slot   = r_held_slot;
        n_expected    = r_expected;
        n_first       = r_first;
        n_first_trig  = r_first_trig;
        n_last_trig   = r_last_trig;
        n_ext         = r_ext;
        n_frames_in   = r_frames_in;
        n_frames_bad  = r_frames_bad;
        n_frames_ovf  = r_frames_ovf;
        n_status      = ST_EMPTY;
        n_id          = '0;
        n_payload     = '0;
        ring_we       = 1'b0;
        if (fire) begin
            unique case (r_in_action)
                ACT_FRAME: begin
                    n_frames_in = r_frames_in + 32'd1;
                    if (r_wr_slot == r_held_slot) begin
                        // slot still held by the reader
                        n_frames_ovf = r_frames_ovf + 32'd1;
                        n_status     = ST_OVERFLOW;
                    end else begin
                        if (r_first) begin
                            n_first      = 1'b0;
                            n_ext        = r_in_ext;
                            n_first_trig = {{(WordW-LowW){1'b0}}, r_in_low};
                        end
                        n_expected = unw.exp_next;
                        if (unw.bad) begin
                            n_frames_bad = r_frames_bad + 32'd1;
                            n_status     = ST_BAD;
                        end else begin
                            ring_we       = 1'b1;
                            n_last_trig   = unw.id;
                            n_write_total = r_write_total + 32'd1;
                            n_wr_slot     = (r_wr_slot == LAST_SLOT) ? '0
                                                                     : r_wr_slot + 1'b1;
                            n_status      = ST_STORED;
                            n_id          = unw.id;
                        end
                    end
                end
                ACT_CLEAR: begin
                    n_write_total = r_read_total;
                    n_wr_slot     = r_rd_slot;
                    n_status      = ST_EMPTY;
                end
                ACT_PEEK, ACT_POP: begin
                    if (!empty) begin
                        n_held_slot = r_rd_slot;
                        n_status    = ST_READ;
                        n_id        = ring_rdata[2*WordW-1:WordW];
                        n_payload   = ring_rdata[WordW-1:0];
                        if (r_in_action == ACT_POP) begin
                            n_read_total = r_read_total + 32'd1;
                            n_rd_slot    = (r_rd_slot == LAST_SLOT) ? '0
                                                                    : r_rd_slot + 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = ST_EMPTY;
                end
            endcase
        end
    end

    // ring: read is aimed at the slot the next beat will see
    tidu_ring #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (2 * WordW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ring_we),
        .i_waddr (r_wr_slot),
        .i_wdata ({unw.id, r_in_payload}),
        .i_raddr (n_rd_slot),
        .o_rdata (ring_rdata)
    );

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap         <= GAP_RESET;
            r_out_valid   <= 1'b0;
            r_write_total <= '0;
            r_read_total  <= '0;
            r_wr_slot     <= '0;
            r_rd_slot     <= '0;
            r_held_slot   <= LAST_SLOT;
            r_expected    <= '0;
            r_first       <= 1'b1;
            r_first_trig  <= '0;
            r_last_trig   <= '0;
            r_ext         <= '0;
            r_frames_in   <= '0;
            r_frames_bad  <= '0;
            r_frames_ovf  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_write_total <= n_write_total;
            r_read_total  <= n_read_total;
            r_wr_slot     <= n_wr_slot;
            r_rd_slot     <= n_rd_slot;
            r_held_slot   <= n_held_slot;
            r_expected    <= n_expected;
            r_first       <= n_first;
            r_first_trig  <= n_first_trig;
            r_last_trig   <= n_last_trig;
            r_ext         <= n_ext;
            r_frames_in   <= n_frames_in;
            r_frames_bad  <= n_frames_bad;
            r_frames_ovf  <= n_frames_ovf;
        end
        if (fire) begin
            r_out_status  <= n_status;
            r_out_id      <= n_id;
            r_out_payload <= n_payload;
        end
    end

    // outputs: totals change only when a result beat is loaded
    assign o_status         = r_out_status;
    assign o_trigger_id     = r_out_id;
    assign o_entry_payload  = r_out_payload;
    assign o_occupancy      = occ_full[OccW-1:0];
    assign o_start_trigger  = r_first_trig;
    assign o_latest_trigger = r_last_trig;
    assign o_input_total    = r_frames_in;
    assign o_bad_total      = r_frames_bad;
    assign o_overflow_total = r_frames_ovf;
    assign o_extension      = r_ext;

    // a stored beat reports the latest trigger it just set
    a_stored_latest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_STORED) |-> (r_last_trig == r_out_id))
        else $error("stored beat ID differs from latest trigger");

    // a pop on a non-empty ring advances the read total by one
    a_pop_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_action == ACT_POP && !empty)
        |=> (r_read_total == $past(r_read_total) + 32'd1))
        else $error("pop did not advance read total");

    // the ring never holds more than DEPTH entries
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_full <= DEPTH)
        else $error("ring occupancy out of range");

    // write and read slots agree after a clear
    a_clear_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_action == ACT_CLEAR) |=> (r_wr_slot == r_rd_slot))
        else $error("clear left write slot apart from read slot");

endmodule
